// ----- src/rhfm_pkg.sv -----
// rhfm_pkg: constants, codes and helpers for the clock health and failover monitor
// no dependencies; imported by the divider, the top level and the bench

package rhfm_pkg;

  localparam int unsigned WORD_W        = 32;
  localparam int unsigned RATE_W        = 10;
  localparam int unsigned MS_PER_SEC    = 1000;
  localparam int unsigned FROZEN_MS     = 1200;
  localparam int unsigned RETRY_SPACING = 5;
  localparam int unsigned FAILED_FACTOR = 300;

  // divisor is 5*rate (at most 5115)
  localparam int unsigned DIVR_W   = 13;
  localparam int unsigned DIV_CNT_W = $clog2(WORD_W);
  // rate*300 is at most 306900
  localparam int unsigned FAIL_LIM_W = 19;

  // x/1000 == (x * ceil(2^38/1000)) >> 38 for every 32-bit x
  localparam int unsigned      DIV1000_MAGIC_W = 29;
  localparam logic [28:0]      DIV1000_MAGIC   = 29'd274877907;
  localparam int unsigned      DIV1000_SHIFT   = 38;
  localparam int unsigned      MUL_W           = WORD_W + DIV1000_MAGIC_W;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRESENT    = 2'd0,
    REG_POLL_RATE  = 2'd1,
    REG_LOST_POWER = 2'd2,
    REG_START_BASE = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_WARN   = 2'd1,
    STATUS_FAILED = 2'd2
  } status_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  localparam logic [WORD_W-1:0] WORD_MAX = '1;

  function automatic logic [WORD_W-1:0] sat_inc(input logic [WORD_W-1:0] v);
    sat_inc = (v == WORD_MAX) ? v : v + WORD_W'(1);
  endfunction

endpackage

// ----- src/rhfm_if.sv -----
// rhfm_poll_if / rhfm_result_if: valid/ready channels of the monitor
// no dependencies; status is carried as a plain 2-bit field

interface rhfm_poll_if;
  logic        valid;
  logic        ready;
  logic [31:0] tick_ms;
  logic        restart_ok;
  logic        read_valid;
  logic [31:0] read_seconds;

  modport source (output valid, tick_ms, restart_ok, read_valid, read_seconds,
                  input ready);
  modport sink   (input valid, tick_ms, restart_ok, read_valid, read_seconds,
                  output ready);
endinterface

interface rhfm_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] time_seconds;
  logic        restart_tried;
  logic [1:0]  status;

  modport source (output valid, time_seconds, restart_tried, status, input ready);
  modport sink   (input valid, time_seconds, restart_tried, status, output ready);
endinterface

// ----- src/rhfm_div.sv -----
// rhfm_div: restoring divider giving the remainder, one quotient bit per cycle
// depends on rhfm_pkg

module rhfm_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [rhfm_pkg::WORD_W-1:0]   dividend,
  input  logic [rhfm_pkg::DIVR_W-1:0]   divisor,
  output rhfm_pkg::div_stat_t           stat,
  output logic [rhfm_pkg::DIVR_W-1:0]   remainder
);
  import rhfm_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [WORD_W-1:0]    acc;
  logic [DIVR_W-1:0]    rem;
  logic [DIVR_W-1:0]    dvr;
  logic [DIVR_W:0]      trial;
  logic                 qbit;

  // shift in next dividend bit, try to subtract
  always_comb begin
    trial = {rem, acc[WORD_W-1]} - {1'b0, dvr};
    qbit  = ~trial[DIVR_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        acc  <= dividend;
        rem  <= '0;
        dvr  <= divisor;
      end else if (busy) begin
        acc <= {acc[WORD_W-2:0], qbit};
        rem <= qbit ? trial[DIVR_W-1:0] : {rem[DIVR_W-2:0], acc[WORD_W-1]};
        cnt <= cnt + DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(WORD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign remainder = rem;

endmodule

// ----- src/rtc_health_failover_monitor.sv -----
// rtc_health_failover_monitor: top level of the clock health and failover monitor
// depends on rhfm_pkg, rhfm_if.sv (channel interfaces) and rhfm_div (remainder divider)
//
//   channel  | dir | handshake    | payload
//   ---------+-----+--------------+--------------------------------------------
//   poll     | in  | valid/ready  | tick_ms, restart_ok, read_valid, read_seconds
//   result   | out | valid/ready  | time_seconds, restart_tried, status
//   cfg      | in  | cfg_we only  | cfg_idx, cfg_data (write only, no wait)
//
// a poll is taken in S_IDLE, tick_ms/1000 is formed by reciprocal multiply in S_DIV,
// and S_FIN commits it; the commit loads the result register and frees the input
// while the retry spacing is checked (present, failing, nonzero rate) a bit-serial pass
// in rhfm_div for restart_fail_count mod 5*poll_rate runs first, in S_MOD, before S_DIV
// a new request is taken while the previous result still waits; it is then
// held before commit until the result register is free
// rst is synchronous and active high, and loads the register reset values

module rtc_health_failover_monitor (
  input  logic                            clk,
  input  logic                            rst,
  rhfm_poll_if.sink                       poll,
  rhfm_result_if.source                   result,
  input  logic                            cfg_we,
  input  logic [rhfm_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [rhfm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rhfm_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MOD,
    S_DIV,
    S_FIN
  } state_t;

  state_t state;

  // configuration
  logic              present;
  logic [RATE_W-1:0] rate;
  logic              lost_power;

  // monitor state
  logic [WORD_W-1:0] current_time;
  logic [WORD_W-1:0] fallback_base;
  logic [WORD_W-1:0] last_read;
  logic [WORD_W-1:0] last_read_tick;
  logic [WORD_W-1:0] last_tick_sec;   // last_read_tick / 1000, kept alongside
  logic [WORD_W-1:0] invalid_count;
  logic [WORD_W-1:0] restart_fail_count;
  logic              frozen_flag;

  // latched request and per-poll results
  logic [WORD_W-1:0] tick_q;
  logic              rok_q;
  logic              valid_q;
  logic [WORD_W-1:0] secs_q;
  logic              attempt;
  logic [WORD_W-1:0] tick_sec;

  // divider hookup
  logic              div_start;
  logic [WORD_W-1:0] div_a;
  logic [DIVR_W-1:0] div_b;
  div_stat_t         div_st;
  logic [DIVR_W-1:0] div_r;

  // tick_ms / 1000 as a reciprocal multiply
  logic [MUL_W-1:0]  tick_prod;

  // output register
  logic out_valid;
  logic tried_q;

  rhfm_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .stat      (div_st),
    .remainder (div_r)
  );

  // derived config values and control terms
  logic [DIVR_W-1:0]     spacing;
  logic [FAIL_LIM_W-1:0] fail_lim;
  logic                  failing;
  logic                  accept;
  logic                  need_mod;
  logic                  commit;

  assign spacing   = ({3'b0, rate} << 2) + {3'b0, rate};
  assign fail_lim  = {9'b0, rate} * FAIL_LIM_W'(FAILED_FACTOR);
  assign failing   = invalid_count > {22'b0, rate};
  assign accept    = poll.valid && poll.ready;
  assign need_mod  = accept && present && failing && (spacing != '0);
  assign commit    = (state == S_FIN) && (!out_valid || result.ready);
  assign tick_prod = MUL_W'(tick_q) * MUL_W'(DIV1000_MAGIC);

  // next state of the monitor for the latched poll
  logic [WORD_W-1:0] fb_time;
  logic [WORD_W-1:0] elapsed;
  logic [WORD_W-1:0] base_e;
  logic [WORD_W-1:0] inv_e;
  logic              go;
  logic [WORD_W-1:0] ct_n;
  logic [WORD_W-1:0] base_n;
  logic [WORD_W-1:0] lr_n;
  logic [WORD_W-1:0] lrt_n;
  logic [WORD_W-1:0] lts_n;
  logic [WORD_W-1:0] inv_n;
  logic [WORD_W-1:0] rfc_n;
  logic              frz_n;
  logic              tried_n;

  always_comb begin
    fb_time = fallback_base + tick_sec;
    elapsed = tick_q - last_read_tick;
    base_e  = frozen_flag ? fallback_base : current_time - last_tick_sec;
    inv_e   = invalid_count;
    go      = 1'b0;
    ct_n    = current_time;
    base_n  = fallback_base;
    lr_n    = last_read;
    lrt_n   = last_read_tick;
    lts_n   = last_tick_sec;
    inv_n   = invalid_count;
    rfc_n   = restart_fail_count;
    frz_n   = frozen_flag;
    tried_n = 1'b0;

    if (!present) begin
      // no external clock: always the fallback time
      ct_n = fb_time;
    end else begin
      go = 1'b1;
      if (failing) begin
        if (!attempt) begin
          // between restart attempts
          rfc_n = sat_inc(restart_fail_count);
          ct_n  = fb_time;
          go    = 1'b0;
        end else if (!rok_q) begin
          // attempt made and failed
          rfc_n   = sat_inc(restart_fail_count);
          ct_n    = fb_time;
          tried_n = 1'b1;
          go      = 1'b0;
        end else begin
          // restart worked, read handled as usual
          rfc_n   = '0;
          inv_e   = '0;
          inv_n   = '0;
          tried_n = 1'b1;
        end
      end
      if (go) begin
        if (!valid_q) begin
          inv_n = sat_inc(inv_e);
          ct_n  = fb_time;
        end else if (secs_q == last_read) begin
          // repeated value: frozen once it has stood too long
          if (elapsed > WORD_W'(FROZEN_MS)) begin
            frz_n  = 1'b1;
            base_n = base_e;
            inv_n  = sat_inc(inv_e);
            ct_n   = base_e + tick_sec;
          end
        end else begin
          // fresh read
          ct_n  = secs_q;
          lr_n  = secs_q;
          lrt_n = tick_q;
          lts_n = tick_sec;
          frz_n = 1'b0;
          inv_n = '0;
        end
      end
    end
  end

  // sequencer, state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      div_start          <= 1'b0;
      out_valid          <= 1'b0;
      tried_q            <= 1'b0;
      present            <= 1'b1;
      rate               <= RATE_W'(10);
      lost_power         <= 1'b0;
      current_time       <= '0;
      fallback_base      <= '0;
      last_read          <= '0;
      last_read_tick     <= '0;
      last_tick_sec      <= '0;
      invalid_count      <= '0;
      restart_fail_count <= '0;
      frozen_flag        <= 1'b0;
    end else begin
      // divider only runs for the spacing check
      div_start <= need_mod;

      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_idx))
          REG_PRESENT:    present    <= cfg_data[0];
          REG_POLL_RATE:  rate       <= cfg_data[RATE_W-1:0];
          REG_LOST_POWER: lost_power <= cfg_data[0];
          REG_START_BASE: fallback_base <= cfg_data[WORD_W-1:0];
          default: ;
        endcase
      end

      // a commit refills the result register, else a delivery empties it
      if (commit) begin
        out_valid <= 1'b1;
      end else if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            tick_q    <= poll.tick_ms;
            rok_q     <= poll.restart_ok;
            valid_q   <= poll.read_valid;
            secs_q    <= poll.read_seconds;
            attempt   <= 1'b1;
            if (need_mod) begin
              // spacing check first
              div_a <= restart_fail_count;
              div_b <= spacing;
              state <= S_MOD;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_MOD: begin
          if (div_st.done) begin
            attempt <= (div_r == '0);
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          tick_sec <= WORD_W'(tick_prod >> DIV1000_SHIFT);
          state    <= S_FIN;
        end
        S_FIN: begin
          if (commit) begin
            current_time       <= ct_n;
            fallback_base      <= base_n;
            last_read          <= lr_n;
            last_read_tick     <= lrt_n;
            last_tick_sec      <= lts_n;
            invalid_count      <= inv_n;
            restart_fail_count <= rfc_n;
            frozen_flag        <= frz_n;
            tried_q            <= tried_n;
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // status from the post-poll state; monitor state only changes at a commit, after delivery
  status_t status_c;

  always_comb begin
    priority if (!present || (restart_fail_count > {13'b0, fail_lim})) begin
      status_c = STATUS_FAILED;
    end else if (lost_power || failing) begin
      status_c = STATUS_WARN;
    end else begin
      status_c = STATUS_OK;
    end
  end

  assign poll.ready           = (state == S_IDLE);
  assign result.valid         = out_valid;
  assign result.time_seconds  = current_time;
  assign result.restart_tried = tried_q;
  assign result.status        = status_c;

  // a taken request keeps the block busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !poll.ready)
    else $error("request accepted but block still ready");

  // the divider is never restarted mid-pass
  a_div_no_overlap: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_st.busy)
    else $error("divider started while busy");

  // a new result only appears from a commit
  a_result_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_FIN))
    else $error("result raised outside commit");

  // counters saturate instead of wrapping
  a_rfc_saturates: assert property (@(posedge clk) disable iff (rst)
    (restart_fail_count == WORD_MAX) |=>
      (restart_fail_count == WORD_MAX) || (restart_fail_count == '0))
    else $error("restart failure count wrapped");

  a_inv_saturates: assert property (@(posedge clk) disable iff (rst)
    (invalid_count == WORD_MAX) |=>
      (invalid_count == WORD_MAX) || (invalid_count == '0))
    else $error("invalid count wrapped");

endmodule

// ----- tb/rtc_health_failover_monitor_tb.sv -----
// rtc_health_failover_monitor_tb: self-checking bench for the clock health and failover monitor
// drives poll requests and register writes, predicts every result and compares it field by field
// depends on rhfm_pkg, rhfm_if.sv and the rtc_health_failover_monitor RTL
`timescale 1ns / 100ps

module rtc_health_failover_monitor_tb;
  import rhfm_pkg::*;

  // timing of the run
  localparam int unsigned RESET_CYCLES  = 10;
  localparam int unsigned SETTLE_CYCLES = 200;
  localparam int unsigned HOLD_CYCLES   = 600;
  localparam int unsigned LIMIT_CYCLES  = 1_500_000;
  localparam int unsigned PRINT_LIMIT   = 40;

  // behavior constants of the monitor
  localparam logic [31:0] MS_PER_S        = 32'd1000;
  localparam logic [31:0] FROZEN_LIMIT_MS = 32'd1200;
  localparam logic [31:0] RETRY_STEP      = 32'd5;
  localparam logic [63:0] FAIL_FACTOR     = 64'd300;
  localparam logic [31:0] ALL_ONES        = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [31:0] time_seconds;
    logic        restart_tried;
    status_t     status;
  } poll_result_t;

  logic     clk = 1'b0;
  logic     rst;
  logic     cfg_we;
  cfg_reg_t cfg_idx;
  logic [31:0] cfg_data;

  rhfm_poll_if   poll_ch ();
  rhfm_result_if result_ch ();

  rtc_health_failover_monitor DUT (
    .clk      (clk),
    .rst      (rst),
    .poll     (poll_ch),
    .result   (result_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // mirror of the register file and of the monitor state
  // ---------------------------------------------------------------------------
  logic        cfg_present;
  logic [9:0]  cfg_rate;
  logic        cfg_lost_power;
  logic [31:0] cfg_start_base;

  logic [31:0] now_secs;            // time reported after the last request
  logic [31:0] fallback_secs_base;  // base for the tick-derived time
  logic [31:0] prev_read;           // last fresh read of the external clock
  logic [31:0] prev_read_tick;      // tick at which that read arrived
  logic [31:0] bad_read_count;      // invalid or frozen reads in a row
  logic [31:0] retry_fail_count;    // polls spent failing since the last good restart
  logic        stuck_seen;          // frozen read already caught, base taken

  poll_result_t expected_q[$];      // predicted results, oldest first
  int unsigned  mismatch_count = 0;
  int unsigned  cycle_count = 0;

  // handshake pacing for the sender and the receiver
  logic        sender_gaps = 1'b0;
  logic        receiver_stalls = 1'b0;
  logic        hold_request = 1'b0;

  // random traffic generator state
  logic [31:0] gen_tick;
  logic [31:0] gen_secs;

  task automatic reset_mirror();
    cfg_present        = 1'b1;
    cfg_rate           = 10'd10;
    cfg_lost_power     = 1'b0;
    cfg_start_base     = '0;
    now_secs           = '0;
    fallback_secs_base = '0;
    prev_read          = '0;
    prev_read_tick     = '0;
    bad_read_count     = '0;
    retry_fail_count   = '0;
    stuck_seen         = 1'b0;
  endtask

  // counters stick at all ones
  function automatic logic [31:0] bump(input logic [31:0] v);
    return (v == ALL_ONES) ? v : v + 32'd1;
  endfunction

  function automatic logic [31:0] fallback_secs(input logic [31:0] tick);
    return fallback_secs_base + tick / MS_PER_S;
  endfunction

  function automatic status_t health_now();
    if (!cfg_present || 64'(retry_fail_count) > 64'(cfg_rate) * FAIL_FACTOR)
      return STATUS_FAILED;
    if (cfg_lost_power || bad_read_count > 32'(cfg_rate))
      return STATUS_WARN;
    return STATUS_OK;
  endfunction

  // works out the result of one poll request and advances the mirrored state
  function automatic poll_result_t predict_poll(input logic [31:0] tick, input logic rok,
                                                input logic vld, input logic [31:0] secs);
    poll_result_t r;
    logic [31:0]  spacing;
    logic [31:0]  elapsed;
    logic         tried;
    logic         settled;
    tried   = 1'b0;
    settled = 1'b0;
    spacing = 32'(cfg_rate) * RETRY_STEP;
    elapsed = tick - prev_read_tick;
    if (!cfg_present) begin
      // no external clock at all: tick-derived time only
      now_secs = fallback_secs(tick);
      settled  = 1'b1;
    end else if (bad_read_count > 32'(cfg_rate)) begin
      // failing: restart attempts only on multiples of the spacing, every poll at zero rate
      if (spacing != '0 && (retry_fail_count % spacing) != '0) begin
        retry_fail_count = bump(retry_fail_count);
        now_secs         = fallback_secs(tick);
        settled          = 1'b1;
      end else begin
        tried = 1'b1;
        if (!rok) begin
          retry_fail_count = bump(retry_fail_count);
          now_secs         = fallback_secs(tick);
          settled          = 1'b1;
        end else begin
          retry_fail_count = '0;
          bad_read_count   = '0;
        end
      end
    end
    if (!settled) begin
      if (!vld) begin
        bad_read_count = bump(bad_read_count);
        now_secs       = fallback_secs(tick);
      end else if (secs == prev_read) begin
        // same value again: only a stall longer than the frozen limit counts
        if (elapsed > FROZEN_LIMIT_MS) begin
          if (!stuck_seen) begin
            stuck_seen         = 1'b1;
            fallback_secs_base = now_secs - prev_read_tick / MS_PER_S;
          end
          bad_read_count = bump(bad_read_count);
          now_secs       = fallback_secs(tick);
        end
      end else begin
        now_secs       = secs;
        prev_read      = secs;
        stuck_seen     = 1'b0;
        prev_read_tick = tick;
        bad_read_count = '0;
      end
    end
    r.time_seconds  = now_secs;
    r.restart_tried = tried;
    r.status        = health_now();
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // pacing: mostly short gaps, now and then a long one
  // ---------------------------------------------------------------------------
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 20);
    return $urandom_range(30, 150);
  endfunction

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------
  // offers one poll request, waits for it to be taken and records its predicted result
  task automatic send_poll(input logic [31:0] tick, input logic rok, input logic vld,
                           input logic [31:0] secs);
    int unsigned gap;
    gap = 0;
    if (sender_gaps && $urandom_range(0, 99) < 35) gap = idle_len();
    if (gap != 0) begin
      poll_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    poll_ch.valid        <= 1'b1;
    poll_ch.tick_ms      <= tick;
    poll_ch.restart_ok   <= rok;
    poll_ch.read_valid   <= vld;
    poll_ch.read_seconds <= secs;
    do @(posedge clk); while (poll_ch.ready !== 1'b1);
    expected_q.push_back(predict_poll(tick, rok, vld, secs));
  endtask

  // stops offering and waits until every predicted result has been seen
  task automatic drain_results();
    poll_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // register writes only happen with the monitor idle
  task automatic write_cfg(input cfg_reg_t idx, input logic [31:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_PRESENT:    cfg_present = value[0];
      REG_POLL_RATE:  cfg_rate = value[9:0];
      REG_LOST_POWER: cfg_lost_power = value[0];
      REG_START_BASE: begin
        cfg_start_base     = value;
        fallback_secs_base = value;
      end
      default: ;
    endcase
  endtask

  task automatic step_tick();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3)       gen_tick = gen_tick + $urandom;
    else if (r < 12) gen_tick = gen_tick + $urandom_range(1000, 4000);
    else             gen_tick = gen_tick + $urandom_range(0, 400);
  endtask

  // external clock running normally, with an occasional jump
  task automatic send_healthy(input int unsigned len, input int unsigned rok_pct);
    int unsigned r;
    repeat (len) begin
      step_tick();
      r = $urandom_range(0, 99);
      if (r < 2)       gen_secs = $urandom;
      else if (r < 4)  gen_secs = ALL_ONES - $urandom_range(0, 3);
      else if (r < 55) gen_secs = gen_secs + 32'd1;
      send_poll(gen_tick, $urandom_range(0, 99) < rok_pct, 1'b1, gen_secs);
    end
  endtask

  // external clock lost: either invalid reads or a value that stops moving
  task automatic send_outage(input int unsigned len, input int unsigned rok_pct);
    logic frozen;
    frozen = 1'($urandom_range(0, 1));
    repeat (len) begin
      step_tick();
      if (frozen) send_poll(gen_tick, $urandom_range(0, 99) < rok_pct, 1'b1, gen_secs);
      else        send_poll(gen_tick, $urandom_range(0, 99) < rok_pct, 1'b0, $urandom);
    end
  endtask

  // mix of healthy stretches, outages and unstructured requests
  task automatic run_traffic(input int unsigned n_items, input int unsigned outage_pct,
                             input int unsigned max_outage, input int unsigned rok_pct);
    int unsigned sent;
    int unsigned len;
    int unsigned kind;
    sent = 0;
    while (sent < n_items) begin
      sender_gaps     = ($urandom_range(0, 4) != 0);
      receiver_stalls = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 49) == 0) drain_results();
      kind = $urandom_range(0, 99);
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, max_outage) : $urandom_range(1, 12);
      if (kind < 6) len = 1;
      if (len > n_items - sent) len = n_items - sent;
      if (kind < 6)
        send_poll($urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom);
      else if (kind < 6 + outage_pct)
        send_outage(len, rok_pct);
      else
        send_healthy(len, rok_pct);
      sent += len;
    end
  endtask

  // ---------------------------------------------------------------------------
  // receiver side: random stalls, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (receiver_stalls && $urandom_range(0, 99) < 20) begin
        result_ch.ready <= 1'b0;
        repeat (idle_len()) @(posedge clk);
      end else begin
        result_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("%0t ns: %s mismatch, got %h expected %h", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    poll_result_t want;
    if (!rst && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", result_ch.time_seconds, '0);
      end else begin
        want = expected_q.pop_front();
        if (result_ch.time_seconds !== want.time_seconds)
          report_mismatch("time_seconds", result_ch.time_seconds, want.time_seconds);
        if (result_ch.restart_tried !== want.restart_tried)
          report_mismatch("restart_tried", 32'(result_ch.restart_tried),
                          32'(want.restart_tried));
        if (result_ch.status !== want.status)
          report_mismatch("status", 32'(result_ch.status), 32'(want.status));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // directed tests
  // ---------------------------------------------------------------------------
  // tick extremes, wrap of the elapsed time and the frozen-read boundary
  task automatic test_frozen_read_and_wrap();
    send_poll(32'd0, 1'b0, 1'b1, 32'd0);              // same as reset value, nothing moves
    send_poll(ALL_ONES, 1'b1, 1'b1, ALL_ONES);        // fresh read at the top of both ranges
    send_poll(32'd1199, 1'b0, 1'b1, ALL_ONES);        // exactly 1200 ms across the wrap
    send_poll(32'd1200, 1'b0, 1'b1, ALL_ONES);        // 1201 ms: frozen, base taken
    send_poll(32'd2500, 1'b1, 1'b1, ALL_ONES);        // still frozen, base kept
    send_poll(32'd3000, 1'b0, 1'b1, 32'd1000);        // clock moves again
  endtask

  // at rate 1 the retry spacing is five polls
  task automatic test_restart_spacing();
    drain_results();
    write_cfg(REG_POLL_RATE, 32'd1);
    send_poll(32'd3100, 1'b0, 1'b0, 32'hA5A5_A5A5);
    send_poll(32'd3200, 1'b0, 1'b0, 32'h5A5A_5A5A);   // count above rate: warning
    send_poll(32'd3300, 1'b0, 1'b1, 32'd2000);        // attempt fails
    repeat (4) send_poll(32'd3400, 1'b1, 1'b1, 32'd2000);  // between attempts
    send_poll(32'd3500, 1'b1, 1'b1, 32'd2001);        // attempt succeeds, read used
  endtask

  // zero rate: every failing poll attempts, one failed attempt already means failed
  task automatic test_zero_rate();
    drain_results();
    write_cfg(REG_POLL_RATE, 32'd0);
    send_poll(32'd3600, 1'b0, 1'b0, 32'd0);
    send_poll(32'd3700, 1'b0, 1'b1, 32'd2002);
    send_poll(32'd3800, 1'b1, 1'b1, 32'd2002);
  endtask

  // no external clock: time from the base, wrap of base plus seconds
  task automatic test_absent_clock();
    drain_results();
    write_cfg(REG_PRESENT, 32'd0);
    write_cfg(REG_START_BASE, ALL_ONES);
    send_poll(ALL_ONES, 1'b1, 1'b1, 32'd12345);
    send_poll(32'd0, 1'b0, 1'b0, ALL_ONES);
  endtask

  task automatic test_lost_power();
    drain_results();
    write_cfg(REG_PRESENT, 32'd1);
    write_cfg(REG_LOST_POWER, 32'd1);
    write_cfg(REG_POLL_RATE, 32'd10);
    send_poll(32'd4000, 1'b0, 1'b1, 32'd3000);
  endtask

  // ---------------------------------------------------------------------------
  // random tests
  // ---------------------------------------------------------------------------
  task automatic test_random_nominal();
    drain_results();
    write_cfg(REG_LOST_POWER, 32'd0);
    write_cfg(REG_START_BASE, 32'd0);
    gen_tick = 32'hFFF0_0000;
    gen_secs = 32'h6000_0000;
    run_traffic(180, 15, 40, 30);
  endtask

  // result side held off while requests keep coming, so the input stalls
  task automatic test_backpressure();
    drain_results();
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    hold_request    = 1'b1;
    send_healthy(12, 20);
  endtask

  task automatic test_random_zero_rate();
    drain_results();
    write_cfg(REG_POLL_RATE, 32'd0);
    write_cfg(REG_LOST_POWER, 32'd1);
    write_cfg(REG_START_BASE, ALL_ONES);
    run_traffic(120, 30, 10, 40);
  endtask

  // one outage long enough to cross the failed threshold at rate 1
  task automatic test_random_long_outage();
    drain_results();
    write_cfg(REG_POLL_RATE, 32'd1);
    write_cfg(REG_LOST_POWER, 32'd0);
    write_cfg(REG_START_BASE, $urandom);
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
    send_outage(320, 0);
    run_traffic(60, 25, 400, 10);
  endtask

  task automatic test_random_odd_rates();
    drain_results();
    write_cfg(REG_POLL_RATE, 32'd7);
    run_traffic(100, 25, 60, 25);
    drain_results();
    write_cfg(REG_POLL_RATE, 32'd23);
    run_traffic(60, 25, 60, 25);
  endtask

  task automatic test_random_fast_and_absent();
    drain_results();
    write_cfg(REG_PRESENT, 32'd0);
    write_cfg(REG_START_BASE, $urandom);
    run_traffic(40, 20, 20, 50);
    drain_results();
    write_cfg(REG_PRESENT, 32'd1);
    write_cfg(REG_POLL_RATE, 32'd1000);
    run_traffic(60, 20, 20, 50);
  endtask

  // ---------------------------------------------------------------------------
  // sequence of the run
  // ---------------------------------------------------------------------------
  initial begin
    rst                  <= 1'b1;
    cfg_we               <= 1'b0;
    cfg_idx              <= REG_PRESENT;
    cfg_data             <= '0;
    poll_ch.valid        <= 1'b0;
    poll_ch.tick_ms      <= '0;
    poll_ch.restart_ok   <= 1'b0;
    poll_ch.read_valid   <= 1'b0;
    poll_ch.read_seconds <= '0;
    reset_mirror();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_frozen_read_and_wrap();
    test_restart_spacing();
    test_zero_rate();
    test_absent_clock();
    test_lost_power();
    test_random_nominal();
    test_backpressure();
    test_random_zero_rate();
    test_random_long_outage();
    test_random_odd_rates();
    test_random_fast_and_absent();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
